// ===== sv/trcd_pkg.sv =====
// Shared types, constants and helpers for the tristate remote code decoder.
package trcd_pkg;

  // Field widths
  localparam int WIDTH_W   = 24;
  localparam int UNIT_W    = 16;
  localparam int ADDR_W    = 13;
  localparam int CMD_W     = 5;
  localparam int BOUND_W   = 25;
  localparam int CNT_W     = 6;
  localparam int OUT_PAD_W = 24;

  // Timing in base units
  localparam int SYNC_UNITS   = 124;
  localparam int NARROW_UNITS = 4;
  localparam int WIDE_UNITS   = 12;

  // Frame shape
  localparam logic [CNT_W-1:0] LAST_PULSE = 6'd47;
  localparam int               SYM_IDX_W  = 4;

  // Defaults
  localparam logic [UNIT_W-1:0] PULSE_UNIT_RST    = 16'd100;
  localparam int                ADDR_SYMBOLS_DEF  = 8;
  localparam int                QUEUE_DEPTH       = 4;

  // Tristate symbol codes, first received bit in the MSB
  localparam logic [3:0] SYM_ZERO  = 4'h5;
  localparam logic [3:0] SYM_ONE   = 4'ha;
  localparam logic [3:0] SYM_FLOAT = 4'h6;

  // Request kind carried on in_tuser
  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  typedef enum logic {
    PH_SYNC = 1'b0,
    PH_BITS = 1'b1
  } trcd_phase_t;

  // Classified request as passed from the front end to the back end
  typedef struct packed {
    logic is_read;
    logic sync_hit;
    logic narrow_hit;
    logic wide_hit;
  } trcd_class_t;

  // Open window lo < w < hi
  typedef struct packed {
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
  } trcd_win_t;

  typedef struct packed {
    trcd_win_t sync_w;
    trcd_win_t narrow_w;
    trcd_win_t wide_w;
  } trcd_bounds_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] val;
  } trcd_sym_t;

  // Window bounds from the unit length: limit is floor(3u/2), sync tolerance eight limits
  function automatic trcd_bounds_t calc_bounds(input logic [UNIT_W-1:0] unit);
    logic [BOUND_W-1:0] u;
    logic [BOUND_W-1:0] lim;
    logic [BOUND_W-1:0] sync_c;
    logic [BOUND_W-1:0] sync_t;
    logic [BOUND_W-1:0] nar_c;
    logic [BOUND_W-1:0] wid_c;
    trcd_bounds_t       b;
    u        = {{(BOUND_W-UNIT_W){1'b0}}, unit};
    lim      = (u + (u << 1)) >> 1;
    sync_c   = (u << 7) - (u << 2);
    sync_t   = lim << 3;
    nar_c    = u << 2;
    wid_c    = (u << 3) + (u << 2);
    b.sync_w.lo   = sync_c - sync_t;
    b.sync_w.hi   = sync_c + sync_t;
    b.narrow_w.lo = nar_c - lim;
    b.narrow_w.hi = nar_c + lim;
    b.wide_w.lo   = wid_c - lim;
    b.wide_w.hi   = wid_c + lim;
    return b;
  endfunction

  // Nibble to tristate symbol; F counts as 2
  function automatic trcd_sym_t decode_sym(input logic [3:0] nib);
    trcd_sym_t s;
    s.ok  = 1'b1;
    s.val = 2'd0;
    unique case (nib)
      SYM_ZERO:  s.val = 2'd0;
      SYM_ONE:   s.val = 2'd1;
      SYM_FLOAT: s.val = 2'd2;
      default:   s.ok  = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// ===== sv/trcd_front.sv =====
// Front end: input stage, window bounds and pulse classification.
module trcd_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [trcd_pkg::UNIT_W-1:0]      cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [trcd_pkg::WIDTH_W-1:0]     in_tdata,
  input  logic                             in_tuser,
  input  logic                             q_full,
  output logic                             q_push,
  output trcd_pkg::trcd_class_t            q_wdata
);

  trcd_pkg::trcd_bounds_t             bounds_r;
  trcd_pkg::trcd_bounds_t             bounds_nxt;
  logic                               stg_v_r;
  logic                               stg_func_r;
  logic [trcd_pkg::WIDTH_W-1:0]       stg_width_r;
  logic [trcd_pkg::BOUND_W-1:0]       w;

  // Bounds follow the unit register, recomputed on each write
  always_comb begin
    bounds_nxt = trcd_pkg::calc_bounds(cfg_wdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bounds_r <= trcd_pkg::calc_bounds(trcd_pkg::PULSE_UNIT_RST);
    end else if (cfg_we) begin
      bounds_r <= bounds_nxt;
    end
  end

  // Input stage: refills as soon as its request moves into the queue
  assign in_tready = !stg_v_r || !q_full;
  assign q_push    = stg_v_r && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      stg_v_r <= 1'b1;
    end else if (q_push) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      stg_func_r  <= in_tuser;
      stg_width_r <= in_tdata;
    end
  end

  // Classify against the three open windows
  assign w = {{(trcd_pkg::BOUND_W-trcd_pkg::WIDTH_W){1'b0}}, stg_width_r};

  always_comb begin
    q_wdata.is_read    = (stg_func_r == trcd_pkg::FUNC_READ);
    q_wdata.sync_hit   = (w > bounds_r.sync_w.lo)   && (w < bounds_r.sync_w.hi);
    q_wdata.narrow_hit = (w > bounds_r.narrow_w.lo) && (w < bounds_r.narrow_w.hi);
    q_wdata.wide_hit   = (w > bounds_r.wide_w.lo)   && (w < bounds_r.wide_w.hi);
  end

endmodule

// ===== sv/trcd_queue.sv =====
// Short queue of classified requests between front and back end.
module trcd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  trcd_pkg::trcd_class_t wdata,
  input  logic                  pop,
  output trcd_pkg::trcd_class_t rdata,
  output logic                  full,
  output logic                  empty
);

  localparam int DEPTH = trcd_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  trcd_pkg::trcd_class_t  slot_r [DEPTH];
  logic [PTR_W-1:0]       wptr_r;
  logic [PTR_W-1:0]       rptr_r;
  logic [CNT_W-1:0]       cnt_r;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = slot_r[rptr_r];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/trcd_back.sv =====
// Back end: frame sequencer, symbol accumulation, held code and result register.
module trcd_back #(
  parameter int ADDR_SYMBOLS = trcd_pkg::ADDR_SYMBOLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_empty,
  input  trcd_pkg::trcd_class_t             q_rdata,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [trcd_pkg::OUT_PAD_W-1:0]    out_tdata,
  output logic                              out_tuser
);

  localparam logic [trcd_pkg::SYM_IDX_W-1:0] ADDR_SYM_N = trcd_pkg::SYM_IDX_W'(ADDR_SYMBOLS);
  localparam int AW = trcd_pkg::ADDR_W;
  localparam int CW = trcd_pkg::CMD_W;

  trcd_pkg::trcd_phase_t              phase_r, phase_nxt;
  logic [trcd_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [2:0]                         nib_r, nib_nxt;
  logic [AW-1:0]                      addr_r, addr_nxt;
  logic [CW-1:0]                      cmd_r, cmd_nxt;
  logic                               bad_r, bad_nxt;
  logic                               held_r, held_nxt;
  logic [AW-1:0]                      held_addr_r, held_addr_nxt;
  logic [CW-1:0]                      held_cmd_r, held_cmd_nxt;
  logic                               out_v_r, out_v_nxt;
  logic                               out_code_v_r;
  logic [AW-1:0]                      out_addr_r;
  logic [CW-1:0]                      out_cmd_r;

  logic                               bit_in;
  trcd_pkg::trcd_sym_t                sym;
  logic                               pulse_go;
  logic                               read_go;

  // A read waits for the result register; pulses never stall
  assign q_pop    = !q_empty && (!q_rdata.is_read || !out_v_r || out_tready);
  assign read_go  = q_pop && q_rdata.is_read;
  assign pulse_go = q_pop && !q_rdata.is_read && !held_r;
  assign bit_in   = !q_rdata.narrow_hit;
  assign sym      = trcd_pkg::decode_sym({nib_r, bit_in});

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= trcd_pkg::PH_SYNC;
      cnt_r       <= '0;
      bad_r       <= 1'b0;
      held_r      <= 1'b0;
      held_addr_r <= '0;
      held_cmd_r  <= '0;
      addr_r      <= '0;
      cmd_r       <= '0;
      out_v_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      bad_r       <= bad_nxt;
      held_r      <= held_nxt;
      held_addr_r <= held_addr_nxt;
      held_cmd_r  <= held_cmd_nxt;
      addr_r      <= addr_nxt;
      cmd_r       <= cmd_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nib_r <= nib_nxt;
    if (read_go) begin
      out_code_v_r <= held_r;
      out_addr_r   <= held_r ? held_addr_r : '0;
      out_cmd_r    <= held_r ? held_cmd_r  : '0;
    end
  end

  // Frame sequencer
  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    nib_nxt       = nib_r;
    addr_nxt      = addr_r;
    cmd_nxt       = cmd_r;
    bad_nxt       = bad_r;
    held_nxt      = held_r;
    held_addr_nxt = held_addr_r;
    held_cmd_nxt  = held_cmd_r;
    out_v_nxt     = out_v_r;

    if (out_tready) begin
      out_v_nxt = 1'b0;
    end

    if (read_go) begin
      out_v_nxt = 1'b1;
      held_nxt  = 1'b0;
    end

    if (pulse_go) begin
      unique case (phase_r)
        trcd_pkg::PH_SYNC: begin
          cnt_nxt  = '0;
          addr_nxt = '0;
          cmd_nxt  = '0;
          bad_nxt  = 1'b0;
          if (q_rdata.sync_hit) begin
            phase_nxt = trcd_pkg::PH_BITS;
          end
        end
        trcd_pkg::PH_BITS: begin
          if (!q_rdata.narrow_hit && !q_rdata.wide_hit) begin
            // bad pulse width drops the frame
            phase_nxt = trcd_pkg::PH_SYNC;
          end else begin
            nib_nxt = {nib_r[1:0], bit_in};
            cnt_nxt = cnt_r + 1'b1;
            // nibble complete: fold the symbol in
            if (cnt_r[1:0] == 2'b11) begin
              if (!sym.ok) begin
                bad_nxt = 1'b1;
              end else if (cnt_r[5:2] < ADDR_SYM_N) begin
                addr_nxt = AW'((addr_r << 1) + addr_r + {{(AW-2){1'b0}}, sym.val});
              end else begin
                cmd_nxt = CW'((cmd_r << 1) + {{(CW-2){1'b0}}, sym.val});
              end
            end
            if (cnt_r == trcd_pkg::LAST_PULSE) begin
              cnt_nxt   = '0;
              phase_nxt = trcd_pkg::PH_SYNC;
              if (!bad_nxt) begin
                held_nxt      = 1'b1;
                held_addr_nxt = addr_nxt;
                held_cmd_nxt  = cmd_nxt;
              end
            end
          end
        end
        default: phase_nxt = trcd_pkg::PH_SYNC;
      endcase
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_code_v_r;
  assign out_tdata  = {{(trcd_pkg::OUT_PAD_W-AW-CW){1'b0}}, out_cmd_r, out_addr_r};

endmodule

// ===== sv/tristate_remote_code_decoder.sv =====
// Top level of the tristate remote code decoder: front end, queue, back end.
//
//  channel  | direction | signals                               | payload
//  ---------+-----------+---------------------------------------+------------------------------
//  in_      | slave     | in_tvalid in_tready in_tdata in_tuser | pulse width / read request
//  out_     | master    | out_tvalid out_tready out_tdata ...   | code, one per read request
//  cfg_     | write     | cfg_we cfg_wdata                      | pulse unit in timer ticks
//
// One request per cycle sustained while no read waits on a stalled result. A request
// is registered in the input stage, where it is classified against the window bounds,
// then passes through the queue before the back end applies it. Reset (rst_n,
// synchronous) clears the frame state, the held code and the queue, and sets the pulse
// unit to 100. A stalled result holds back a read at the queue head and all requests
// behind it; earlier pulses keep draining, and the queue fills before in_tready drops.
module tristate_remote_code_decoder #(
  parameter int ADDR_SYMBOLS = trcd_pkg::ADDR_SYMBOLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [trcd_pkg::UNIT_W-1:0]       cfg_wdata,    // pulse_unit
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [trcd_pkg::WIDTH_W-1:0]      in_tdata,     // [23:0] pulse_width
  input  logic                              in_tuser,     // [0] func
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [trcd_pkg::OUT_PAD_W-1:0]    out_tdata,    // [12:0] code_address, [17:13] code_command
  output logic                              out_tuser     // [0] code_valid
);

  logic                   q_push;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_empty;
  trcd_pkg::trcd_class_t  q_wdata;
  trcd_pkg::trcd_class_t  q_rdata;

  trcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  trcd_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  trcd_back #(
    .ADDR_SYMBOLS (ADDR_SYMBOLS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_rdata    (q_rdata),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Queue is never written when full nor read when empty
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue read while empty");

  // A read with no held code returns an all-zero code
  a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("empty read carries a non-zero code");

  // A stalled input means the input stage is occupied and the queue is full
  a_ready_low_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_full)
    else $error("input stalled with room in the queue");

endmodule

// ===== verif/trcd_tb_pkg.sv =====
// Request tracker and code predictor for the tristate remote code decoder testbench.
package trcd_tb_pkg;

  import trcd_pkg::*;

  localparam int FRAME_PULSES = 48;
  localparam int FRAME_SYMS   = 12;

  // One read result as seen on the output channel
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic [CMD_W-1:0]  cmd;
  } code_t;

  class code_tracker;
    logic [UNIT_W-1:0] unit_ticks;
    trcd_phase_t       rx_phase;
    int unsigned       pulse_cnt;
    logic [47:0]       shift_bits;
    logic              have_code;
    logic [ADDR_W-1:0] code_addr;
    logic [CMD_W-1:0]  code_cmd;
    code_t             pending_codes[$];
    int unsigned       mismatches;

    function new();
      unit_ticks = PULSE_UNIT_RST;
      rx_phase   = PH_SYNC;
      pulse_cnt  = 0;
      shift_bits = '0;
      have_code  = 1'b0;
      code_addr  = '0;
      code_cmd   = '0;
      mismatches = 0;
    endfunction

    function void set_unit(logic [UNIT_W-1:0] u);
      unit_ticks = u;
    endfunction

    function int unsigned waiting();
      return pending_codes.size();
    endfunction

    // Open window: centre - tol < w < centre + tol
    function bit in_win(longint unsigned w, longint unsigned c, longint unsigned t);
      return (c >= t) && (w > c - t) && (w < c + t);
    endfunction

    // Twelve tristate symbols, first received nibble first; bad nibble drops the frame
    function void decode_frame();
      int unsigned addr;
      int unsigned cmd;
      int unsigned sym;
      logic [3:0]  nib;
      addr = 0;
      cmd  = 0;
      for (int i = 0; i < FRAME_SYMS; i++) begin
        nib = shift_bits[(FRAME_SYMS - 1 - i) * 4 +: 4];
        case (nib)
          SYM_ZERO:  sym = 0;
          SYM_ONE:   sym = 1;
          SYM_FLOAT: sym = 2;
          default:   return;
        endcase
        if (i < ADDR_SYMBOLS_DEF) addr = addr * 3 + sym;
        else cmd = (cmd << 1) + sym;
      end
      code_addr = addr[ADDR_W-1:0];
      code_cmd  = cmd[CMD_W-1:0];
      have_code = 1'b1;
    endfunction

    // Apply one accepted request; a read queues the code it must return
    function void note_request(logic func, logic [WIDTH_W-1:0] width);
      code_t           res;
      longint unsigned u;
      longint unsigned lim;
      longint unsigned w;
      u   = unit_ticks;
      lim = (3 * u) / 2;
      w   = width;
      if (func == FUNC_READ) begin
        res.valid = have_code;
        res.addr  = have_code ? code_addr : '0;
        res.cmd   = have_code ? code_cmd : '0;
        have_code = 1'b0;
        pending_codes.push_back(res);
        return;
      end
      // pulses are ignored while a code waits to be read
      if (have_code) return;
      if (rx_phase == PH_SYNC) begin
        shift_bits = '0;
        pulse_cnt  = 0;
        if (in_win(w, SYNC_UNITS * u, 8 * lim)) rx_phase = PH_BITS;
        return;
      end
      if (in_win(w, NARROW_UNITS * u, lim)) begin
        shift_bits = {shift_bits[46:0], 1'b0};
      end else if (in_win(w, WIDE_UNITS * u, lim)) begin
        shift_bits = {shift_bits[46:0], 1'b1};
      end else begin
        rx_phase = PH_SYNC;
        return;
      end
      pulse_cnt++;
      if (pulse_cnt >= FRAME_PULSES) begin
        pulse_cnt = 0;
        rx_phase  = PH_SYNC;
        decode_frame();
      end
    endfunction

    // Compare a returned code with the oldest outstanding read
    function void check_code(logic valid, logic [ADDR_W-1:0] addr, logic [CMD_W-1:0] cmd);
      code_t exp;
      if (pending_codes.size() == 0) begin
        $error("code returned with no read request outstanding");
        mismatches++;
        return;
      end
      exp = pending_codes.pop_front();
      if (valid !== exp.valid) begin
        $error("code_valid: expected %0d, got %0d", exp.valid, valid);
        mismatches++;
      end
      if (addr !== exp.addr) begin
        $error("code_address: expected %0d, got %0d", exp.addr, addr);
        mismatches++;
      end
      if (cmd !== exp.cmd) begin
        $error("code_command: expected %0d, got %0d", exp.cmd, cmd);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// Testbench top for the tristate remote code decoder: stimulus, stalls and checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import trcd_pkg::*;
  import trcd_tb_pkg::*;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [UNIT_W-1:0]  cfg_wdata  = '0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [WIDTH_W-1:0] in_tdata   = '0;
  logic               in_tuser   = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b1;
  logic [OUT_PAD_W-1:0] out_tdata;
  logic               out_tuser;

  code_tracker codes;
  bit          calm = 1'b0;
  int unsigned sent = 0;

  always #6 clk = ~clk;

  tristate_remote_code_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Width strictly inside the open window around c
  function automatic logic [WIDTH_W-1:0] width_in(longint unsigned c, longint unsigned t);
    return WIDTH_W'(c - t + 1 + $urandom_range(0, 32'(2 * t - 2)));
  endfunction

  // Width that breaks a frame: window edges, the gap between windows, a sync, or junk
  function automatic logic [WIDTH_W-1:0] width_bad(longint unsigned u);
    longint unsigned lim;
    lim = (3 * u) / 2;
    case ($urandom_range(0, 7))
      0: return WIDTH_W'(NARROW_UNITS * u - lim);
      1: return WIDTH_W'(NARROW_UNITS * u + lim);
      2: return WIDTH_W'(WIDE_UNITS * u - lim);
      3: return WIDTH_W'(WIDE_UNITS * u + lim);
      4: return WIDTH_W'(8 * u);
      5: return width_in(SYNC_UNITS * u, 8 * lim);
      6: return '0;
      default: return WIDTH_W'($urandom_range(0, 32'hFF_FFFF));
    endcase
  endfunction

  // Twelve symbols; optionally one forced to an illegal nibble
  function automatic logic [47:0] make_frame(bit garble);
    logic [47:0] f;
    logic [3:0]  nib;
    int unsigned same;
    bit          uniform;
    uniform = ($urandom_range(0, 19) == 0);
    same    = $urandom_range(0, 2);
    for (int i = 0; i < FRAME_SYMS; i++) begin
      case (uniform ? same : $urandom_range(0, 2))
        0:       nib = SYM_ZERO;
        1:       nib = SYM_ONE;
        default: nib = SYM_FLOAT;
      endcase
      f[(FRAME_SYMS - 1 - i) * 4 +: 4] = nib;
    end
    if (garble) begin
      do nib = 4'($urandom_range(0, 15));
      while (nib == SYM_ZERO || nib == SYM_ONE || nib == SYM_FLOAT);
      f[$urandom_range(0, FRAME_SYMS - 1) * 4 +: 4] = nib;
    end
    return f;
  endfunction

  // One request on the input channel, noted once accepted
  task automatic send(logic func, logic [WIDTH_W-1:0] w);
    int unsigned gap;
    gap = pick_idle();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    codes.note_request(func, w);
    sent++;
  endtask

  task automatic send_read();
    send(FUNC_READ, WIDTH_W'($urandom_range(0, 32'hFF_FFFF)));
  endtask

  // Sync then 48 pulses; abort_at > 0 puts a bad width at that pulse
  task automatic send_frame(longint unsigned u, logic [47:0] bits, int unsigned abort_at);
    longint unsigned lim;
    lim = (3 * u) / 2;
    send(FUNC_PULSE, width_in(SYNC_UNITS * u, 8 * lim));
    for (int k = 1; k <= FRAME_PULSES; k++) begin
      if (k == abort_at) begin
        send(FUNC_PULSE, width_bad(u));
        return;
      end
      // a read mid-frame must leave the decoding progress alone
      if ($urandom_range(0, 63) == 0) send_read();
      send(FUNC_PULSE, bits[FRAME_PULSES - k] ? width_in(WIDE_UNITS * u, lim)
                                              : width_in(NARROW_UNITS * u, lim));
    end
  endtask

  // Unit change only once every read has returned and pulses have drained
  task automatic write_unit(logic [UNIT_W-1:0] u);
    in_tvalid <= 1'b0;
    while (codes.waiting() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= u;
    @(posedge clk);
    cfg_we <= 1'b0;
    codes.set_unit(u);
    repeat (2) @(posedge clk);
  endtask

  // Output back-pressure
  initial begin
    int unsigned stall;
    forever begin
      repeat ($urandom_range(1, 24)) @(posedge clk);
      stall = pick_idle();
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      codes.check_code(out_tuser, out_tdata[12:0], out_tdata[17:13]);
  end

  // Watchdog
  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence
  initial begin
    longint unsigned u;
    longint unsigned lim;
    longint unsigned sc;
    longint unsigned st;
    logic [UNIT_W-1:0] plan [5];
    int unsigned budget;
    int unsigned r;
    int unsigned guard;
    codes = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset unit
    u   = PULSE_UNIT_RST;
    lim = (3 * u) / 2;
    sc  = SYNC_UNITS * u;
    st  = 8 * lim;
    send_read();
    send(FUNC_PULSE, '0);
    send(FUNC_PULSE, '1);
    send(FUNC_PULSE, WIDTH_W'(sc - st));
    send(FUNC_PULSE, WIDTH_W'(sc + st));
    send(FUNC_PULSE, WIDTH_W'(sc - st + 1));
    send(FUNC_PULSE, WIDTH_W'(NARROW_UNITS * u - lim));
    send(FUNC_PULSE, WIDTH_W'(sc + st - 1));
    send(FUNC_PULSE, WIDTH_W'(NARROW_UNITS * u - lim + 1));
    send(FUNC_PULSE, WIDTH_W'(NARROW_UNITS * u + lim - 1));
    send(FUNC_PULSE, WIDTH_W'(WIDE_UNITS * u - lim + 1));
    send(FUNC_PULSE, WIDTH_W'(WIDE_UNITS * u + lim - 1));
    send(FUNC_PULSE, WIDTH_W'(NARROW_UNITS * u + lim));
    send(FUNC_READ, '0);
    send(FUNC_PULSE, WIDTH_W'(sc));
    send(FUNC_PULSE, WIDTH_W'(WIDE_UNITS * u - lim));
    send(FUNC_PULSE, WIDTH_W'(sc));
    send(FUNC_PULSE, WIDTH_W'(WIDE_UNITS * u + lim));
    send_read();

    // Random phases over several unit settings
    plan = '{16'd1, 16'hFFFF, 16'd3, 16'd100, UNIT_W'($urandom_range(2, 65534))};
    foreach (plan[p]) begin
      write_unit(plan[p]);
      u      = plan[p];
      budget = sent + 280;
      while (sent < budget) begin
        calm = ($urandom_range(0, 7) == 0);
        r    = $urandom_range(0, 99);
        if (r < 55) begin
          // clean frame, usually read back; otherwise later pulses meet a held code
          send_frame(u, make_frame(1'b0), 0);
          if ($urandom_range(0, 4) != 0) send_read();
        end else if (r < 65) begin
          send_frame(u, make_frame(1'b1), 0);
          send_read();
        end else if (r < 77) begin
          send_frame(u, make_frame(1'b0),
                     ($urandom_range(0, 3) == 0) ? FRAME_PULSES : $urandom_range(1, 48));
          if ($urandom_range(0, 1) == 0) send_read();
        end else if (r < 89) begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) == 0)
              send(FUNC_PULSE, WIDTH_W'($urandom_range(0, 32'hFF_FFFF)));
            else
              send(FUNC_PULSE, width_bad(u));
          end
        end else begin
          repeat ($urandom_range(1, 3)) send_read();
        end
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain outstanding reads, then let the pipeline settle
    guard = 0;
    while (codes.waiting() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
    if (codes.waiting() != 0) begin
      $error("%0d read request(s) never answered", codes.waiting());
      codes.mismatches++;
    end
    if (codes.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
